### hdl/sgep_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgep_pkg: shared types and constants of the scanline edge pairing block
// Field widths, register map, result kinds and the transaction structs that
// travel between the block's modules.
// ----------------------------------------------------------------------------
package sgep_pkg;

   // field widths
   localparam int LUMA_W   = 8;
   localparam int ROW_W    = 10;
   localparam int COL_W    = 10;
   localparam int SCAN_W   = 6;
   localparam int EROW_W   = 11;
   localparam int THR_W    = 7;
   localparam int GRAD_W   = 10;

   // default row width actually used from the row field
   localparam int ROW_BITS_DEF = 10;

   // register map
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_THRESHOLD = 3'd0;
   localparam logic [THR_W-1:0]      THRESHOLD_RESET    = 7'd8;

   // result kind
   typedef enum logic {
      EDGE_BEGIN = 1'b0,
      EDGE_END   = 1'b1
   } edge_kind_type;

   // one input transaction
   typedef struct packed {
      logic [LUMA_W-1:0] luma;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  column;
      logic [SCAN_W-1:0] scanline_index;
      logic              first_sample;
      logic              last_sample;
   } sgep_item_type;

   // one result transaction
   typedef struct packed {
      edge_kind_type     edge_kind;
      logic [EROW_W-1:0] edge_row;
      logic [COL_W-1:0]  edge_column;
      logic              pair_found;
      logic [EROW_W-1:0] pair_begin_row;
      logic [EROW_W-1:0] pair_center_row;
      logic [SCAN_W-1:0] pair_scanline;
   } sgep_result_type;

endpackage
`default_nettype wire

### hdl/sgep_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgep_csr: configuration register file
// APB-style slave holding the brightness threshold; pready is always high.
// ----------------------------------------------------------------------------
module sgep_csr
   import sgep_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output logic      [THR_W-1:0]      threshold
);

   logic [THR_W-1:0] threshold_ff;
   logic [THR_W-1:0] threshold_in;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready && (paddr == CSR_ADDR_THRESHOLD);

   // threshold register
   always_comb begin
      threshold_in = threshold_ff;
      if (wr_en) begin
         threshold_in = pwdata[THR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      if (paddr == CSR_ADDR_THRESHOLD) begin
         prdata = CSR_DATA_W'(threshold_ff);
      end
   end

   assign threshold = threshold_ff;

endmodule
`default_nettype wire

### hdl/sgep_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgep_core: gradient peak tracking and edge pairing
// Holds the scan line state and evaluates one sample per cycle while fire is high: gradient,
// rising and falling peak checks, begin/end edge report and pairing.
// ----------------------------------------------------------------------------
module sgep_core
   import sgep_pkg::*;
#(
   parameter int ROW_BITS = ROW_BITS_DEF
)
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            fire,
   input  wire sgep_item_type   item,
   input  wire logic [THR_W-1:0] threshold,
   output logic                 hit,
   output sgep_result_type      result
);

   localparam int ER_W = ROW_BITS + 1;

   // scan line state
   logic [LUMA_W-1:0]        prev_luma_ff, prev_luma_in;
   logic signed [GRAD_W-1:0] grad_high_ff, grad_high_in;
   logic signed [GRAD_W-1:0] grad_low_ff,  grad_low_in;
   logic [ER_W-1:0]          peak_row_ff,  peak_row_in;
   logic                     pending_ff,   pending_in;
   logic [ER_W-1:0]          begin_row_ff, begin_row_in;

   logic signed [GRAD_W-1:0] t_pos, t_neg, g;
   logic [LUMA_W-1:0]        prev_eff;
   logic signed [GRAD_W-1:0] high0, low0, high1, low1;
   logic [ER_W-1:0]          peak0, peak1, here;
   logic                     pend0, pend1;
   logic                     rise, fall, end_hit, begin_hit;
   logic [ER_W:0]            pair_sum;

   // threshold and row of this sample
   assign t_pos = signed'({2'b00, threshold, 1'b0});
   assign t_neg = -t_pos;
   assign here  = ER_W'(ROW_BITS'(item.row)) + ER_W'(1);

   // restart on the first sample of a line
   always_comb begin
      if (item.first_sample) begin
         prev_eff = item.luma;
         high0    = t_neg;
         low0     = t_pos;
         pend0    = 1'b0;
         peak0    = here;
      end else begin
         prev_eff = prev_luma_ff;
         high0    = grad_high_ff;
         low0     = grad_low_ff;
         pend0    = pending_ff;
         peak0    = peak_row_ff;
      end
   end

   assign g = signed'({2'b00, item.luma} - {2'b00, prev_eff});

   // rising peak: closes a falling peak into an end edge
   assign rise    = g > high0;
   assign end_hit = rise && (low0 < t_neg);
   assign high1   = rise ? g : high0;
   assign low1    = rise ? t_pos : low0;
   assign peak1   = rise ? here : peak0;
   assign pend1   = end_hit ? 1'b0 : pend0;

   // falling peak: closes a rising peak into a begin edge
   assign fall      = g < low1;
   assign begin_hit = fall && (high1 > t_pos);

   assign pair_sum = {1'b0, begin_row_ff} + {1'b0, peak0};

   // next state
   always_comb begin
      prev_luma_in = item.luma;
      grad_high_in = fall ? t_neg : high1;
      grad_low_in  = fall ? g : low1;
      peak_row_in  = fall ? here : peak1;
      pending_in   = item.last_sample ? 1'b0 : (begin_hit ? 1'b1 : pend1);
      begin_row_in = begin_hit ? peak1 : begin_row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_luma_ff <= '0;
         grad_high_ff <= '0;
         grad_low_ff  <= '0;
         peak_row_ff  <= '0;
         pending_ff   <= 1'b0;
         begin_row_ff <= '0;
      end else if (fire) begin
         prev_luma_ff <= prev_luma_in;
         grad_high_ff <= grad_high_in;
         grad_low_ff  <= grad_low_in;
         peak_row_ff  <= peak_row_in;
         pending_ff   <= pending_in;
         begin_row_ff <= begin_row_in;
      end
   end

   // result transaction (the end and begin edges never fire together)
   assign hit = end_hit || begin_hit;

   always_comb begin
      result             = '0;
      result.edge_column = item.column;
      if (end_hit) begin
         result.edge_kind = EDGE_END;
         result.edge_row  = EROW_W'(peak0);
         if (pend0) begin
            result.pair_found      = 1'b1;
            result.pair_begin_row  = EROW_W'(begin_row_ff);
            result.pair_center_row = EROW_W'(pair_sum[ER_W:1]);
            result.pair_scanline   = item.scanline_index;
         end
      end else begin
         result.edge_kind = EDGE_BEGIN;
         result.edge_row  = EROW_W'(peak1);
      end
   end

endmodule
`default_nettype wire

### hdl/scanline_gradient_edge_pairing_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scanline_gradient_edge_pairing_top: scan line edge detector with pairing
// Input register, peak tracking core, result register.
// ----------------------------------------------------------------------------
// Accepts one luminance sample per clock while req_stall is low. The sample is
// captured in the input register, the core evaluates the gradient against the
// tracked peaks combinationally and any edge is written into the result
// register when the core fires; a stall on the result side delays that.
// Throughput is one sample per cycle while no stall holds, limited only by the
// single state update in the core. A sample that yields no edge still passes
// the core in order. A stall on the result side holds the result register
// and, one item deep behind it, the input register.
// The threshold register should only be written while no sample is in flight.
// ----------------------------------------------------------------------------
module scanline_gradient_edge_pairing_top
   import sgep_pkg::*;
#(
   parameter int ROW_BITS = ROW_BITS_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // sample channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [LUMA_W-1:0]     req_luma,
   input  wire logic [ROW_W-1:0]      req_row,
   input  wire logic [COL_W-1:0]      req_column,
   input  wire logic [SCAN_W-1:0]     req_scanline_index,
   input  wire logic                  req_first_sample,
   input  wire logic                  req_last_sample,
   // edge channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_edge_kind,
   output logic      [EROW_W-1:0]     rsp_edge_row,
   output logic      [COL_W-1:0]      rsp_edge_column,
   output logic                       rsp_pair_found,
   output logic      [EROW_W-1:0]     rsp_pair_begin_row,
   output logic      [EROW_W-1:0]     rsp_pair_center_row,
   output logic      [SCAN_W-1:0]     rsp_pair_scanline,
   // configuration
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   logic             in_valid_ff, in_valid_in;
   sgep_item_type    item_ff, item_in;
   logic             out_valid_ff, out_valid_in;
   sgep_result_type  result_ff, result_in;
   sgep_result_type  core_result;
   logic             core_hit;
   logic             out_free, fire, req_accept;
   logic [THR_W-1:0] threshold;

   // configuration registers
   sgep_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .threshold (threshold)
   );

   // flow control
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign fire       = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   // input register
   always_comb begin
      item_in.luma           = req_luma;
      item_in.row            = req_row;
      item_in.column         = req_column;
      item_in.scanline_index = req_scanline_index;
      item_in.first_sample   = req_first_sample;
      item_in.last_sample    = req_last_sample;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= item_in;
      end
   end

   // peak tracking core
   sgep_core #(
      .ROW_BITS (ROW_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (item_ff),
      .threshold (threshold),
      .hit       (core_hit),
      .result    (core_result)
   );

   // result register
   assign result_in = core_result;

   always_comb begin
      if (fire) begin
         out_valid_in = core_hit;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && core_hit) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_edge_kind       = result_ff.edge_kind;
   assign rsp_edge_row        = result_ff.edge_row;
   assign rsp_edge_column     = result_ff.edge_column;
   assign rsp_pair_found      = result_ff.pair_found;
   assign rsp_pair_begin_row  = result_ff.pair_begin_row;
   assign rsp_pair_center_row = result_ff.pair_center_row;
   assign rsp_pair_scanline   = result_ff.pair_scanline;

endmodule
`default_nettype wire

### hdl/sgep_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgep_checker: port level checks of the edge pairing block
// Watches the result channel for consistency of edges and pairs.
// ----------------------------------------------------------------------------
module sgep_checker
   import sgep_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic              rsp_edge_kind,
   input wire logic [EROW_W-1:0] rsp_edge_row,
   input wire logic              rsp_pair_found,
   input wire logic [EROW_W-1:0] rsp_pair_begin_row,
   input wire logic [EROW_W-1:0] rsp_pair_center_row,
   input wire logic [SCAN_W-1:0] rsp_pair_scanline
);

   // a pair is only closed by an end edge
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pair_found |-> rsp_edge_kind == EDGE_END)
      else $error("pair reported on a begin edge");

   // pair fields are zero without a pair
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pair_found |->
         rsp_pair_begin_row == '0 && rsp_pair_center_row == '0 && rsp_pair_scanline == '0)
      else $error("pair fields set without a pair");

   // center lies between begin and end rows
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pair_found |->
         (rsp_pair_center_row >= rsp_pair_begin_row || rsp_pair_center_row >= rsp_edge_row) &&
         (rsp_pair_center_row <= rsp_pair_begin_row || rsp_pair_center_row <= rsp_edge_row))
      else $error("pair center outside its edges");

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_edge_row) && $stable(rsp_edge_kind))
      else $error("stalled result changed");

endmodule

bind scanline_gradient_edge_pairing_top sgep_checker u_sgep_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_edge_kind       (rsp_edge_kind),
   .rsp_edge_row        (rsp_edge_row),
   .rsp_pair_found      (rsp_pair_found),
   .rsp_pair_begin_row  (rsp_pair_begin_row),
   .rsp_pair_center_row (rsp_pair_center_row),
   .rsp_pair_scanline   (rsp_pair_scanline)
);
`default_nettype wire
